>>> rtl/sdra_pkg.sv
// Package with shared constants, codes and state type for the shared unit allocator.
package sdra_pkg;

    localparam int DEF_TABLE_SLOTS = 32;
    localparam int DEF_COUNT_BITS  = 8;

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 8;
    localparam int REQ_W    = 4;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [FIELD_W-1:0]  field_t;
    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Action codes
    localparam action_t ACT_REGISTER   = 2'd0;
    localparam action_t ACT_UNREGISTER = 2'd1;
    localparam action_t ACT_ACQUIRE    = 2'd2;
    localparam action_t ACT_RELEASE    = 2'd3;

    // Status codes
    localparam status_t STAT_OK    = 3'd0;
    localparam status_t STAT_NONE  = 3'd1;
    localparam status_t STAT_FULL  = 3'd2;
    localparam status_t STAT_EMPTY = 3'd3;
    localparam status_t STAT_ZERO  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_SCAN,
        S_ACQ_SCAN,
        S_REL_READ,
        S_REL_EXEC,
        S_RESP
    } state_t;

endpackage

>>> rtl/shared_device_refcount_allocator.sv
// Shared unit reference-count allocator: slot table, scan sequencer and result register.
// Register scans for the lowest free slot and acquire for the lowest slot it can grant;
// unregister needs no scan, and release reads the one slot it names. The scans step
// through the table one slot per cycle. One item is in work at a time; the next beat is
// taken once the result is in the output register. Reset clears valid bits and control state.
module shared_device_refcount_allocator #(
    parameter int TABLE_SLOTS = sdra_pkg::DEF_TABLE_SLOTS,
    parameter int COUNT_BITS  = sdra_pkg::DEF_COUNT_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sdra_pkg::action_t s_action,
    input  sdra_pkg::field_t  s_func_code,
    input  sdra_pkg::field_t  s_inst_index,
    input  logic              s_any_index,
    input  sdra_pkg::req_t    s_requester,
    input  logic              s_tap_follow,
    input  sdra_pkg::field_t  s_ref_limit,
    input  sdra_pkg::slot_t   s_slot_in,
    output logic              m_valid,
    input  logic              m_ready,
    output sdra_pkg::status_t m_status,
    output sdra_pkg::slot_t   m_slot_out
);
    import sdra_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    // One bit above the slot index so that TABLE_SLOTS itself can be compared against
    localparam int AW = ((SW > SLOT_W) ? SW : SLOT_W) + 1;
    localparam int CW = COUNT_BITS;
    localparam int LW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};

    typedef logic [SW-1:0] idx_t;
    typedef logic [CW-1:0] cnt_t;

    // Table memory, written at one address and read at one
    field_t mem_func   [TABLE_SLOTS];
    field_t mem_inst   [TABLE_SLOTS];
    field_t mem_limit  [TABLE_SLOTS];
    cnt_t   mem_rc     [TABLE_SLOTS];
    cnt_t   mem_fc     [TABLE_SLOTS];
    req_t   mem_oid    [TABLE_SLOTS];
    logic   mem_oset   [TABLE_SLOTS];
    logic   mem_tap    [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] valid_reg;

    state_t state_reg, state_next;

    // Captured input beat
    field_t  func_reg, inst_reg, limit_reg;
    logic    any_reg, follow_reg;
    req_t    req_reg;
    idx_t    slot_idx_reg;
    logic    slot_ok_reg;

    // Scan position and read row
    idx_t    idx_reg, idx_next;
    idx_t    chk_idx_reg;
    logic    chk_vld_reg;
    field_t  row_func, row_inst, row_limit;
    cnt_t    row_rc, row_fc;
    req_t    row_oid;
    logic    row_oset, row_tap;

    // Pending result and output register
    status_t res_status_reg, res_status_next;
    slot_t   res_slot_reg, res_slot_next;
    logic    m_valid_reg;
    status_t m_status_reg;
    slot_t   m_slot_reg;

    // Datapath control
    logic    wr_en;
    idx_t    wr_addr;
    field_t  wr_func, wr_inst, wr_limit;
    cnt_t    wr_rc, wr_fc;
    req_t    wr_oid;
    logic    wr_oset, wr_tap;
    logic    set_valid, clr_valid;
    idx_t    valid_addr;
    logic    res_load;

    // Scan conditions
    logic    reg_free, acq_cand, acq_first, acq_follow, acq_grant, acq_end;
    logic    out_free;
    logic [LW-1:0] rc_w, rcm1_w, lim_w;
    logic [AW-1:0] slot_in_w, slot_out_w;
    cnt_t    rel_fc, rel_rc;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
    endfunction

    function automatic cnt_t sat_dec(input cnt_t v);
        return (v == '0) ? '0 : v - cnt_t'(1);
    endfunction

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot_out = m_slot_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign slot_in_w  = AW'(s_slot_in);

    // Evaluate the slot under test
    always_comb begin
        reg_free   = !valid_reg[idx_reg];
        rc_w       = LW'(row_rc);
        rcm1_w     = LW'(row_rc - cnt_t'(1));
        lim_w      = LW'(row_limit);
        acq_cand   = chk_vld_reg && valid_reg[chk_idx_reg] && (row_func == func_reg)
                     && (any_reg || (row_inst == inst_reg))
                     && (!row_oset || (row_oid == req_reg));
        acq_first  = rc_w < lim_w;
        acq_follow = row_tap && follow_reg && (row_rc != '0) && (rcm1_w < lim_w);
        acq_grant  = acq_cand && (acq_first || acq_follow);
        acq_end    = chk_vld_reg && (chk_idx_reg == LAST_SLOT);
        slot_out_w = AW'(chk_idx_reg);
        rel_fc     = row_tap ? sat_dec(row_fc) : row_fc;
        if (row_tap) begin
            rel_rc = (rel_fc == '0) ? sat_dec(row_rc) : row_rc;
        end else begin
            rel_rc = sat_dec(row_rc);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_action)
                        ACT_REGISTER:   state_next = S_REG_SCAN;
                        ACT_ACQUIRE:    state_next = S_ACQ_SCAN;
                        ACT_RELEASE:    state_next = S_REL_READ;
                        default:        state_next = S_RESP;
                    endcase
                end
            end
            S_REG_SCAN: begin
                if (reg_free || idx_reg == LAST_SLOT) begin
                    state_next = S_RESP;
                end
            end
            S_ACQ_SCAN: begin
                if (acq_grant || acq_end) begin
                    state_next = S_RESP;
                end
            end
            S_REL_READ: state_next = slot_ok_reg ? S_REL_EXEC : S_RESP;
            S_REL_EXEC: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Table writes, valid bits and result selection
    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_func         = row_func;
        wr_inst         = row_inst;
        wr_limit        = row_limit;
        wr_rc           = row_rc;
        wr_fc           = row_fc;
        wr_oid          = row_oid;
        wr_oset         = row_oset;
        wr_tap          = row_tap;
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        valid_addr      = idx_reg;
        res_load        = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        idx_next        = idx_reg + idx_t'(1);
        case (state_reg)
            S_IDLE: begin
                res_load = s_valid;
                res_slot_next = '0;
                res_status_next = STAT_OK;
                idx_next = (s_action == ACT_RELEASE) ? slot_in_w[SW-1:0] : '0;
                if (s_action == ACT_UNREGISTER) begin
                    if (slot_in_w < AW'(TABLE_SLOTS) && valid_reg[slot_in_w[SW-1:0]]) begin
                        clr_valid  = s_valid;
                        valid_addr = slot_in_w[SW-1:0];
                    end else begin
                        res_status_next = STAT_EMPTY;
                    end
                end
            end
            S_REG_SCAN: begin
                if (reg_free) begin
                    wr_en     = 1'b1;
                    wr_addr   = idx_reg;
                    wr_func   = func_reg;
                    wr_inst   = inst_reg;
                    wr_limit  = limit_reg;
                    wr_rc     = '0;
                    wr_fc     = '0;
                    wr_oid    = '0;
                    wr_oset   = 1'b0;
                    wr_tap    = 1'b0;
                    set_valid = 1'b1;
                    res_load  = 1'b1;
                    res_status_next = STAT_OK;
                    res_slot_next   = slot_t'(AW'(idx_reg));
                end else if (idx_reg == LAST_SLOT) begin
                    res_load = 1'b1;
                    res_status_next = STAT_FULL;
                    res_slot_next   = '0;
                end
            end
            S_ACQ_SCAN: begin
                if (acq_grant) begin
                    wr_en   = 1'b1;
                    wr_oid  = req_reg;
                    wr_oset = 1'b1;
                    if (acq_first) begin
                        wr_tap = follow_reg;
                        wr_fc  = follow_reg ? sat_inc(row_fc) : row_fc;
                        wr_rc  = sat_inc(row_rc);
                    end else begin
                        wr_fc  = sat_inc(row_fc);
                    end
                    res_load = 1'b1;
                    res_status_next = STAT_OK;
                    res_slot_next   = slot_out_w[SLOT_W-1:0];
                end else if (acq_end) begin
                    res_load = 1'b1;
                    res_status_next = STAT_NONE;
                    res_slot_next   = '0;
                end
            end
            S_REL_READ: begin
                idx_next = idx_reg;
                if (!slot_ok_reg) begin
                    res_load = 1'b1;
                    res_status_next = STAT_EMPTY;
                    res_slot_next   = '0;
                end
            end
            S_REL_EXEC: begin
                wr_en   = 1'b1;
                wr_addr = slot_idx_reg;
                wr_fc   = rel_fc;
                wr_rc   = rel_rc;
                wr_tap  = row_tap && (rel_fc != '0);
                if (rel_rc == '0) begin
                    wr_oset = 1'b0;
                    wr_oid  = '0;
                end
                res_load = 1'b1;
                res_status_next = (row_rc == '0) ? STAT_ZERO : STAT_OK;
                res_slot_next   = '0;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= (state_reg == S_ACQ_SCAN);
            if (set_valid) begin
                valid_reg[valid_addr] <= 1'b1;
            end
            if (clr_valid) begin
                valid_reg[valid_addr] <= 1'b0;
            end
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input beat, advance the scan, hold the result
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        chk_idx_reg <= idx_reg;
        if (s_valid && s_ready) begin
            func_reg     <= s_func_code;
            inst_reg     <= s_inst_index;
            limit_reg    <= s_ref_limit;
            any_reg      <= s_any_index;
            follow_reg   <= s_tap_follow;
            req_reg      <= s_requester;
            slot_idx_reg <= slot_in_w[SW-1:0];
            slot_ok_reg  <= (slot_in_w < AW'(TABLE_SLOTS)) && valid_reg[slot_in_w[SW-1:0]];
        end
        if (res_load) begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
        end
        if (state_reg == S_RESP && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
        end
    end

    // Table memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_func[wr_addr]  <= wr_func;
            mem_inst[wr_addr]  <= wr_inst;
            mem_limit[wr_addr] <= wr_limit;
            mem_rc[wr_addr]    <= wr_rc;
            mem_fc[wr_addr]    <= wr_fc;
            mem_oid[wr_addr]   <= wr_oid;
            mem_oset[wr_addr]  <= wr_oset;
            mem_tap[wr_addr]   <= wr_tap;
        end
    end

    // Table memory read port, registered
    always_ff @(posedge aclk) begin
        row_func  <= mem_func[idx_reg];
        row_inst  <= mem_inst[idx_reg];
        row_limit <= mem_limit[idx_reg];
        row_rc    <= mem_rc[idx_reg];
        row_fc    <= mem_fc[idx_reg];
        row_oid   <= mem_oid[idx_reg];
        row_oset  <= mem_oset[idx_reg];
        row_tap   <= mem_tap[idx_reg];
    end

endmodule
